### design/idiv_pkg.sv
// ----------------------------------------------------------------------------
// idiv_pkg
// Shared widths, state codes and cell control type for the integer divider.
// ----------------------------------------------------------------------------
`default_nettype none

package idiv_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = 32;
    localparam int CNT_W  = 6;

    // Mode field codes
    localparam logic [1:0] MODE_U32 = 2'd0;
    localparam logic [1:0] MODE_S32 = 2'd1;
    localparam logic [1:0] MODE_U64 = 2'd2;
    localparam logic [1:0] MODE_S64 = 2'd3;

    // Last step index for each operand width
    localparam logic [CNT_W-1:0] LAST_STEP_64 = CNT_W'(DATA_W - 1);
    localparam logic [CNT_W-1:0] LAST_STEP_32 = CNT_W'(HALF_W - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic load;
        logic step;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### design/idiv_cell.sv
// ----------------------------------------------------------------------------
// idiv_cell
// One bit slice of the divider: remainder, divisor and dividend/quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_cell
    import idiv_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       load_q,
    input  wire logic       load_d,
    input  wire logic       r_in,
    input  wire logic       q_in,
    input  wire logic       borrow_in,
    input  wire logic       take,
    output logic            r_bit,
    output logic            q_bit,
    output logic            borrow_out
);

    logic r_reg;
    logic q_reg;
    logic d_reg;
    logic r_next;
    logic q_next;
    logic d_next;
    logic diff;

    // One bit of (shifted remainder - divisor)
    assign diff       = r_in ^ d_reg ^ borrow_in;
    assign borrow_out = (~r_in & d_reg) | (~(r_in ^ d_reg) & borrow_in);

    // Load a fresh request, or shift and conditionally subtract
    always_comb
    begin
        r_next = r_reg;
        q_next = q_reg;
        d_next = d_reg;
        if (ctrl.load)
        begin
            r_next = 1'b0;
            q_next = load_q;
            d_next = load_d;
        end
        else if (ctrl.step)
        begin
            r_next = take ? diff : r_in;
            q_next = q_in;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign r_bit = r_reg;
    assign q_bit = q_reg;

endmodule

`default_nettype wire

### design/idiv_chain.sv
// ----------------------------------------------------------------------------
// idiv_chain
// Row of divider cells; the borrow ripples up, data shifts up one cell a step.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_chain
    import idiv_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [DATA_W-1:0] load_q,
    input  wire logic [DATA_W-1:0] load_d,
    output logic      [DATA_W-1:0] rem,
    output logic      [DATA_W-1:0] quo
);

    logic [DATA_W-1:0] r_bits;
    logic [DATA_W-1:0] q_bits;
    logic [DATA_W-1:0] borrow;
    logic              take;

    // Subtract succeeds if the bit shifted out was set or no borrow came out
    assign take = r_bits[DATA_W-1] | ~borrow[DATA_W-1];

    genvar i;
    generate
        for (i = 0; i < DATA_W; i++)
        begin : g_cell
            logic r_in;
            logic q_in;
            logic b_in;

            if (i == 0)
            begin : g_first
                // Dividend MSB enters the remainder, new quotient bit enters at the bottom
                assign r_in = q_bits[DATA_W-1];
                assign q_in = take;
                assign b_in = 1'b0;
            end
            else
            begin : g_rest
                assign r_in = r_bits[i-1];
                assign q_in = q_bits[i-1];
                assign b_in = borrow[i-1];
            end

            idiv_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .load_q     (load_q[i]),
                .load_d     (load_d[i]),
                .r_in       (r_in),
                .q_in       (q_in),
                .borrow_in  (b_in),
                .take       (take),
                .r_bit      (r_bits[i]),
                .q_bit      (q_bits[i]),
                .borrow_out (borrow[i])
            );
        end
    endgenerate

    assign rem = r_bits;
    assign quo = q_bits;

endmodule

`default_nettype wire

### design/integer_divider_signed_unsigned.sv
// ----------------------------------------------------------------------------
// integer_divider_signed_unsigned
// Signed and unsigned 32/64-bit restoring divider with quotient and remainder.
// ----------------------------------------------------------------------------
// Each request loads the operand magnitudes, takes one step per quotient bit
// (32 in the 32-bit modes, 64 in the 64-bit modes) and then applies signs in
// the fix-up state before the result moves to the output register. The
// step time is set by the borrow chain that ripples through the 64 divider
// cells to produce one quotient bit per cycle. A new request is taken as soon
// as the previous one has moved into the output register, even while that
// result still waits to be taken. A zero divisor raises div_by_zero with a
// zero quotient; 32-bit results are zero-extended to 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_divider_signed_unsigned
    import idiv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        mode,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [DATA_W-1:0] quotient,
    output logic      [DATA_W-1:0] remainder_out,
    output logic                   div_by_zero
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic              wide_reg;
    logic              qneg_reg;
    logic              rneg_reg;
    logic              zero_reg;
    logic [HALF_W-1:0] nlow_reg;
    logic [DATA_W-1:0] quo_out_reg, quo_out_next;
    logic [DATA_W-1:0] rem_out_reg, rem_out_next;
    logic              dbz_reg, dbz_next;

    logic              accept;
    logic              wide_in;
    logic              sgn_in;
    logic [DATA_W-1:0] n_in;
    logic [DATA_W-1:0] d_in;
    logic [DATA_W-1:0] n_neg;
    logic [DATA_W-1:0] d_neg;
    logic              nneg_in;
    logic              dneg_in;
    logic [DATA_W-1:0] un_in;
    logic [DATA_W-1:0] ud_in;
    logic [DATA_W-1:0] load_q;
    logic              emit;
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] q_signed;
    logic [DATA_W-1:0] r_signed;

    assign accept   = in_valid & ~in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Take operand magnitudes at the selected width
    assign wide_in = (mode == MODE_U64) || (mode == MODE_S64);
    assign sgn_in  = (mode == MODE_S32) || (mode == MODE_S64);
    assign n_in    = wide_in ? dividend : {{HALF_W{1'b0}}, dividend[HALF_W-1:0]};
    assign d_in    = wide_in ? divisor  : {{HALF_W{1'b0}}, divisor[HALF_W-1:0]};
    assign n_neg   = DATA_W'(0) - n_in;
    assign d_neg   = DATA_W'(0) - d_in;
    assign nneg_in = sgn_in & (wide_in ? n_in[DATA_W-1] : n_in[HALF_W-1]);
    assign dneg_in = sgn_in & (wide_in ? d_in[DATA_W-1] : d_in[HALF_W-1]);
    assign un_in   = nneg_in ? (wide_in ? n_neg : {{HALF_W{1'b0}}, n_neg[HALF_W-1:0]})
                             : n_in;
    assign ud_in   = dneg_in ? (wide_in ? d_neg : {{HALF_W{1'b0}}, d_neg[HALF_W-1:0]})
                             : d_in;

    // 32-bit dividends sit in the upper half so their MSB shifts out first
    assign load_q  = wide_in ? un_in : {un_in[HALF_W-1:0], {HALF_W{1'b0}}};

    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == S_RUN);

    idiv_chain u_chain (
        .clk    (clk),
        .ctrl   (ctrl),
        .load_q (load_q),
        .load_d (ud_in),
        .rem    (rem),
        .quo    (quo)
    );

    // Hold request attributes for the sign fix-up
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wide_reg <= wide_in;
            qneg_reg <= nneg_in ^ dneg_in;
            rneg_reg <= nneg_in;
            zero_reg <= (d_in == '0);
            nlow_reg <= n_in[HALF_W-1:0];
        end
    end

    // Apply signs, wrap to the selected width and override for a zero divisor
    always_comb
    begin
        q_signed = qneg_reg ? (DATA_W'(0) - quo) : quo;
        r_signed = rneg_reg ? (DATA_W'(0) - rem) : rem;
        if (!wide_reg)
        begin
            q_signed = {{HALF_W{1'b0}}, q_signed[HALF_W-1:0]};
            r_signed = {{HALF_W{1'b0}}, r_signed[HALF_W-1:0]};
        end
        if (zero_reg)
        begin
            q_signed = '0;
            r_signed = wide_reg ? '0 : {{HALF_W{1'b0}}, nlow_reg};
        end
    end

    assign emit = (state_reg == S_DONE) & (~out_valid_reg | ~out_stall);

    // Sequence load, steps and result hand-off
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg & out_stall;
        quo_out_next   = quo_out_reg;
        rem_out_next   = rem_out_reg;
        dbz_next       = dbz_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    count_next = wide_in ? LAST_STEP_64 : LAST_STEP_32;
                end
            end
            S_RUN:
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (emit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    quo_out_next   = q_signed;
                    rem_out_next   = r_signed;
                    dbz_next       = zero_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_out_reg <= quo_out_next;
        rem_out_reg <= rem_out_next;
        dbz_reg     <= dbz_next;
    end

    assign out_valid     = out_valid_reg;
    assign quotient      = quo_out_reg;
    assign remainder_out = rem_out_reg;
    assign div_by_zero   = dbz_reg;

    // A result appears only after the fix-up state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the fix-up cycle");

    // A zero divisor always reports a zero quotient
    a_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_by_zero) |-> (quotient == '0))
        else $error("nonzero quotient with zero divisor");

    // The last step hands over to the fix-up state
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && count_reg == '0) |=> (state_reg == S_DONE))
        else $error("step count did not end the run");

endmodule

`default_nettype wire

### tb/tb_integer_divider_signed_unsigned.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_divider_signed_unsigned
// Self-checking bench for the signed/unsigned 32/64-bit integer divider.
// ----------------------------------------------------------------------------
// A short directed list hits the width extremes, every mode, zero divisors,
// ignored upper operand bits in the 32-bit modes and the most-negative by
// minus-one wrap. Random requests follow, with operands shaped so that
// quotient lengths, signs and magnitudes spread widely. Both handshake sides
// pause at random, with calm stretches in between. A scoreboard computes the
// quotient, remainder and zero-divisor flag for every accepted request and
// checks each returned result in order.
// ----------------------------------------------------------------------------

module tb_integer_divider_signed_unsigned;

    import idiv_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int MAX_WAIT        = 18;
    localparam int DRAIN_CYCLES    = 80;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_REQUESTS = 950;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] MIN64    = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] MAX64    = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
        logic              zero_div;
    } div_result_t;

    // Track accepted requests and compare returned results in order
    class div_scoreboard;
        div_result_t pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Truncating division at the width and signedness the mode selects
        function div_result_t divide(logic [1:0] m, logic [DATA_W-1:0] a,
                                     logic [DATA_W-1:0] b);
            div_result_t       res;
            logic              wide;
            logic              sgn;
            logic              neg_n;
            logic              neg_d;
            logic [DATA_W-1:0] mask;
            logic [DATA_W-1:0] num;
            logic [DATA_W-1:0] den;
            logic [DATA_W-1:0] mag_n;
            logic [DATA_W-1:0] mag_d;
            wide = (m == MODE_U64) || (m == MODE_S64);
            sgn  = (m == MODE_S32) || (m == MODE_S64);
            mask = wide ? {DATA_W{1'b1}} : {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
            num  = a & mask;
            den  = b & mask;
            res  = '0;
            if (den == '0)
            begin
                // zero divisor: the 32-bit modes hand back the dividend
                res.zero_div = 1'b1;
                res.rem      = wide ? '0 : num;
            end
            else
            begin
                neg_n   = sgn && (wide ? num[DATA_W-1] : num[HALF_W-1]);
                neg_d   = sgn && (wide ? den[DATA_W-1] : den[HALF_W-1]);
                mag_n   = neg_n ? ((-num) & mask) : num;
                mag_d   = neg_d ? ((-den) & mask) : den;
                res.quo = mag_n / mag_d;
                res.rem = mag_n % mag_d;
                if (neg_n != neg_d)
                    res.quo = -res.quo;
                if (neg_n)
                    res.rem = -res.rem;
                res.quo = res.quo & mask;
                res.rem = res.rem & mask;
            end
            return res;
        endfunction

        function void note_request(logic [1:0] m, logic [DATA_W-1:0] a,
                                   logic [DATA_W-1:0] b);
            pending.push_back(divide(m, a, b));
        endfunction

        function void check_result(logic [DATA_W-1:0] q, logic [DATA_W-1:0] r,
                                   logic dz);
            div_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with no request pending: quotient %h remainder %h flag %b",
                         $time, q, r, dz);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (q !== want.quo)
            begin
                $display("%0t: quotient expected %h actual %h", $time, want.quo, q);
                errors++;
            end
            if (r !== want.rem)
            begin
                $display("%0t: remainder_out expected %h actual %h", $time, want.rem, r);
                errors++;
            end
            if (dz !== want.zero_div)
            begin
                $display("%0t: div_by_zero expected %b actual %b", $time, want.zero_div, dz);
                errors++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [1:0]        mode      = MODE_U32;
    logic [DATA_W-1:0] dividend  = '0;
    logic [DATA_W-1:0] divisor   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder_out;
    logic              div_by_zero;

    div_scoreboard board;
    int            cycle_count = 0;
    int            send_style;
    int            send_left;
    logic [1:0]    all_modes[4] = '{MODE_U32, MODE_S32, MODE_U64, MODE_S64};

    integer_divider_signed_unsigned dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .dividend      (dividend),
        .divisor       (divisor),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .quotient      (quotient),
        .remainder_out (remainder_out),
        .div_by_zero   (div_by_zero)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Pause length for one handshake: calm, occasional, or busy
    function automatic int draw_wait(input int style);
        case (style)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_WAIT)) : 0;
            default: return int'($urandom_range(0, MAX_WAIT));
        endcase
    endfunction

    // Operand shapes: corner values, full random, short magnitudes, negatives
    function automatic logic [DATA_W-1:0] rand_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = 64'd1;
                    2:       v = ALL_ONES;
                    3:       v = MIN64;
                    4:       v = MAX64;
                    default: v = {v[63:32], 32'h8000_0000};
                endcase
            end
            1, 2, 3: ;
            4, 5, 6: v = v >> $urandom_range(0, DATA_W - 1);
            7:       v = -(v >> $urandom_range(DATA_W / 2, DATA_W - 1));
            8:       v = {v[63:32], v[31:0] >> $urandom_range(0, HALF_W - 1)};
            default: v = {v[63:32], -(v[31:0] >> $urandom_range(8, HALF_W - 1))};
        endcase
        return v;
    endfunction

    // Present one request and hold it until the divider takes it
    task automatic send_division(input logic [1:0] m, input logic [DATA_W-1:0] a,
                                 input logic [DATA_W-1:0] b);
        int pause;
        if (send_left == 0)
        begin
            send_style = $urandom_range(0, 2);
            send_left  = $urandom_range(10, 60);
        end
        send_left--;
        pause = draw_wait(send_style);
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        dividend <= a;
        divisor  <= b;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        board.note_request(m, a, b);
    endtask

    // Drain results with random stalls
    initial
    begin
        int pause;
        int take_style;
        int take_left;
        take_style = 0;
        take_left  = 0;
        @(posedge rst_n);
        forever
        begin
            if (take_left == 0)
            begin
                take_style = $urandom_range(0, 2);
                take_left  = $urandom_range(10, 60);
            end
            take_left--;
            pause = draw_wait(take_style);
            if (pause > 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            board.check_result(quotient, remainder_out, div_by_zero);
        end
    end

    // Reset, directed requests, random requests, then drain
    initial
    begin
        logic [1:0]        m;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        board      = new();
        send_style = 0;
        send_left  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // unsigned 32-bit: extremes, junk in the upper halves, zero divisor
        send_division(MODE_U32, 64'h0000_0000_FFFF_FFFF, 64'd1);
        send_division(MODE_U32, 64'hDEAD_BEEF_0000_0064, 64'h1234_5678_0000_0007);
        send_division(MODE_U32, 64'hFFFF_FFFF_89AB_CDEF, 64'hFFFF_FFFF_0000_0000);
        send_division(MODE_U32, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000);
        send_division(MODE_U32, 64'h0000_0005_0000_0003, 64'h0000_0000_FFFF_FFFF);

        // signed 32-bit: most negative by minus one, sign combinations, zero divisor
        send_division(MODE_S32, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF);
        send_division(MODE_S32, 64'hFFFF_FFFF_FFFF_FFF9, 64'h0000_0000_0000_0002);
        send_division(MODE_S32, 64'h0000_0000_0000_0007, 64'hABCD_0000_FFFF_FFFE);
        send_division(MODE_S32, 64'h0000_0000_FFFF_FFF9, 64'h0000_0000_FFFF_FFFE);
        send_division(MODE_S32, 64'h1111_1111_8000_0001, 64'h5555_5555_0000_0000);
        send_division(MODE_S32, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000);
        send_division(MODE_S32, 64'h0000_0000_8000_0000, 64'h0000_0000_0000_0001);

        // unsigned 64-bit: extremes and zero divisor
        send_division(MODE_U64, ALL_ONES, 64'd1);
        send_division(MODE_U64, ALL_ONES, ALL_ONES);
        send_division(MODE_U64, 64'd12345, ALL_ONES);
        send_division(MODE_U64, ALL_ONES, '0);
        send_division(MODE_U64, '0, '0);
        send_division(MODE_U64, MIN64, 64'd3);

        // signed 64-bit: most negative by minus one, signs, zero divisor
        send_division(MODE_S64, MIN64, ALL_ONES);
        send_division(MODE_S64, MIN64, 64'd1);
        send_division(MODE_S64, -64'sd7, 64'd2);
        send_division(MODE_S64, MAX64, MIN64);
        send_division(MODE_S64, MIN64, '0);
        send_division(MODE_S64, '0, ALL_ONES);

        // random requests, with a share of zero divisors
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            m = all_modes[$urandom_range(0, 3)];
            a = rand_operand();
            b = rand_operand();
            case ($urandom_range(0, 24))
                0:       b = '0;
                1:       b = {b[63:32], 32'h0};
                default: ;
            endcase
            send_division(m, a, b);
        end
        in_valid <= 1'b0;

        // wait out the remaining results, then catch any stray one
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
